@@ sv/rrwd_pkg.sv @@
// ----------------------------------------------------------------------------
// rrwd_pkg
// Shared request codes, result codes, slot status codes and the decision
// record passed from the slot evaluation unit to the sequencer.
// ----------------------------------------------------------------------------
package rrwd_pkg;

   // request codes
   localparam logic [2:0] REQ_ADD      = 3'd0;
   localparam logic [2:0] REQ_ASSIGN   = 3'd1;
   localparam logic [2:0] REQ_MAINT    = 3'd2;
   localparam logic [2:0] REQ_AVAIL    = 3'd3;
   localparam logic [2:0] REQ_COMPLETE = 3'd4;
   localparam logic [2:0] REQ_EXISTS   = 3'd5;

   // result codes
   localparam logic [2:0] RC_OK         = 3'd0;
   localparam logic [2:0] RC_EMPTY      = 3'd1;
   localparam logic [2:0] RC_NONE_AVAIL = 3'd2;
   localparam logic [2:0] RC_NOT_FOUND  = 3'd3;
   localparam logic [2:0] RC_BUSY       = 3'd4;
   localparam logic [2:0] RC_IN_MAINT   = 3'd5;
   localparam logic [2:0] RC_NOT_BUSY   = 3'd6;
   localparam logic [2:0] RC_FULL       = 3'd7;

   // slot status codes
   localparam logic [1:0] SLOT_AVAIL = 2'd0;
   localparam logic [1:0] SLOT_BUSY  = 2'd1;
   localparam logic [1:0] SLOT_MAINT = 2'd2;

   // widths of the result fields
   localparam int RSP_ID_BITS   = 16;
   localparam int RSP_TASK_BITS = 16;

   // decision for the slot under evaluation
   typedef struct packed {
      logic       hit;       // slot ends the walk
      logic       wr;        // rewrite the slot record
      logic [1:0] status;    // new status when rewritten
      logic       set_task;  // store the request task
      logic       clr_task;  // clear the task
      logic       take_task; // report the old task as finished
      logic [2:0] code;      // result code on a hit
   } slot_dec_type;

endpackage

@@ sv/rrwd_ifs.sv @@
// ----------------------------------------------------------------------------
// rrwd_req_if / rrwd_rsp_if
// Valid/ready channels for dispatcher requests and results.
// ----------------------------------------------------------------------------
interface rrwd_req_if #(
   parameter int ID_BITS   = 16,
   parameter int TASK_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [2:0]           req_type;
   logic [ID_BITS-1:0]   worker_id;
   logic [TASK_BITS-1:0] task_tag;
   logic [1:0]           initial_status;

   modport source (output valid, req_type, worker_id, task_tag, initial_status,
                   input ready);
   modport sink   (input valid, req_type, worker_id, task_tag, initial_status,
                   output ready);
endinterface

interface rrwd_rsp_if
   import rrwd_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic [2:0]               result_code;
   logic [RSP_ID_BITS-1:0]   chosen_id;
   logic [RSP_TASK_BITS-1:0] finished_task;

   modport source (output valid, result_code, chosen_id, finished_task,
                   input ready);
   modport sink   (input valid, result_code, chosen_id, finished_task,
                   output ready);
endinterface

@@ sv/rrwd_ram.sv @@
// ----------------------------------------------------------------------------
// rrwd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ sv/rrwd_slot_eval.sv @@
// ----------------------------------------------------------------------------
// rrwd_slot_eval
// Compare unit shared by every step of the ring walk: decides whether the
// slot read this cycle ends the walk and how its record changes.
// ----------------------------------------------------------------------------
module rrwd_slot_eval
   import rrwd_pkg::*;
#(
   parameter int ID_BITS = 16
) (
   input  logic [2:0]         req_type,
   input  logic [ID_BITS-1:0] want_id,
   input  logic [ID_BITS-1:0] slot_id,
   input  logic [1:0]         slot_status,
   output slot_dec_type       dec
);

   logic id_match;

   assign id_match = (slot_id == want_id);

   // decide hit, record update and result code
   always_comb begin
      dec        = '0;
      dec.status = slot_status;
      dec.code   = RC_OK;
      case (req_type)
         REQ_ASSIGN: begin
            dec.hit      = (slot_status == SLOT_AVAIL);
            dec.wr       = dec.hit;
            dec.status   = SLOT_BUSY;
            dec.set_task = 1'b1;
         end
         REQ_MAINT: begin
            dec.hit = id_match;
            if (slot_status == SLOT_BUSY) begin
               dec.code = RC_BUSY;
            end else begin
               dec.wr     = id_match;
               dec.status = SLOT_MAINT;
            end
         end
         REQ_AVAIL: begin
            dec.hit      = id_match;
            dec.wr       = id_match;
            dec.status   = SLOT_AVAIL;
            dec.clr_task = 1'b1;
         end
         REQ_COMPLETE: begin
            dec.hit = id_match;
            if (slot_status == SLOT_BUSY) begin
               dec.wr        = id_match;
               dec.status    = SLOT_AVAIL;
               dec.clr_task  = 1'b1;
               dec.take_task = 1'b1;
            end else if (slot_status == SLOT_MAINT) begin
               dec.code = RC_IN_MAINT;
            end else begin
               dec.code = RC_NOT_BUSY;
            end
         end
         REQ_EXISTS: begin
            dec.hit = id_match;
         end
         default: begin
            dec.hit = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/round_robin_worker_dispatcher.sv @@
// Timing: an add goes from idle through the link state to the result register;
//   a full or empty ring is answered in the cycle after the transfer; lookups
//   and assign walk one ring slot per cycle via the slot record RAM read port.
// Throughput: one request at a time; the next is taken once the result is out
//   or leaves in the same cycle. Request codes 6 and 7 are dropped.
// Reset: synchronous; empties the ring (count, head, tail); no clearing pass.
// ----------------------------------------------------------------------------
// round_robin_worker_dispatcher
// Ring of worker slots in insertion order, walked one slot per cycle by a
// small sequencer around one shared slot compare unit.
// ----------------------------------------------------------------------------
module round_robin_worker_dispatcher
   import rrwd_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int ID_BITS   = 16,
   parameter int TASK_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   rrwd_req_if.sink   req,
   rrwd_rsp_if.source rsp
);

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS = $clog2(SLOTS + 1);
   localparam int REC_BITS = ID_BITS + 2 + TASK_BITS;

   typedef enum logic [1:0] {S_IDLE, S_LINK, S_WALK} state_type;

   state_type                state_ff, state_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [IDX_BITS-1:0]      head_ff, head_in;
   logic [IDX_BITS-1:0]      tail_ff, tail_in;
   logic [IDX_BITS-1:0]      cur_ff, cur_in;
   logic [CNT_BITS-1:0]      steps_ff, steps_in;
   logic [2:0]               type_ff, type_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [TASK_BITS-1:0]     task_ff, task_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               rsp_code_ff, rsp_code_in;
   logic [RSP_ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic [RSP_TASK_BITS-1:0] rsp_task_ff, rsp_task_in;

   logic                     rec_wr;
   logic [IDX_BITS-1:0]      rec_wr_addr;
   logic [REC_BITS-1:0]      rec_wr_data;
   logic [REC_BITS-1:0]      rec_q;
   logic                     nxt_wr;
   logic [IDX_BITS-1:0]      nxt_wr_addr;
   logic [IDX_BITS-1:0]      nxt_wr_data;
   logic [IDX_BITS-1:0]      nxt_q;
   logic [IDX_BITS-1:0]      rd_addr;

   logic [ID_BITS-1:0]       id_q;
   logic [1:0]               st_q;
   logic [TASK_BITS-1:0]     task_q;
   logic [TASK_BITS-1:0]     new_task;
   logic [IDX_BITS-1:0]      new_slot;
   logic                     req_xfer;
   logic                     rsp_free;
   logic                     last_step;
   slot_dec_type             dec;

   // zero-extended views for the fixed-width result fields
   logic [ID_BITS+RSP_ID_BITS-1:0]     id_q_ext;
   logic [ID_BITS+RSP_ID_BITS-1:0]     id_ff_ext;
   logic [TASK_BITS+RSP_TASK_BITS-1:0] task_q_ext;

   assign id_q   = rec_q[REC_BITS-1 -: ID_BITS];
   assign st_q   = rec_q[TASK_BITS+1 -: 2];
   assign task_q = rec_q[TASK_BITS-1:0];

   assign id_q_ext   = {{RSP_ID_BITS{1'b0}}, id_q};
   assign id_ff_ext  = {{RSP_ID_BITS{1'b0}}, id_ff};
   assign task_q_ext = {{RSP_TASK_BITS{1'b0}}, task_q};

   assign new_slot  = count_ff[IDX_BITS-1:0];
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && rsp_free;
   assign req_xfer  = req.valid && req.ready;
   assign last_step = (steps_ff == (count_ff - CNT_BITS'(1)));

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.result_code   = rsp_code_ff;
   assign rsp.chosen_id     = rsp_id_ff;
   assign rsp.finished_task = rsp_task_ff;

   // slot records {id, status, task} and ring links
   rrwd_ram #(.WIDTH(REC_BITS), .DEPTH(SLOTS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_wr),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rec_q)
   );

   rrwd_ram #(.WIDTH(IDX_BITS), .DEPTH(SLOTS)) u_nxt_ram (
      .clock   (clock),
      .wr_en   (nxt_wr),
      .wr_addr (nxt_wr_addr),
      .wr_data (nxt_wr_data),
      .rd_addr (rd_addr),
      .rd_data (nxt_q)
   );

   // shared compare unit for the slot read this cycle
   rrwd_slot_eval #(.ID_BITS(ID_BITS)) u_eval (
      .req_type    (type_ff),
      .want_id     (id_ff),
      .slot_id     (id_q),
      .slot_status (st_q),
      .dec         (dec)
   );

   // start the walk at the head, then follow the link just read
   assign rd_addr = (state_ff == S_WALK) ? nxt_q : head_ff;

   always_comb begin
      if (dec.set_task) begin
         new_task = task_ff;
      end else if (dec.clr_task) begin
         new_task = '0;
      end else begin
         new_task = task_q;
      end
   end

   // RAM write ports
   always_comb begin
      rec_wr      = 1'b0;
      rec_wr_addr = new_slot;
      rec_wr_data = {req.worker_id, req.initial_status, req.task_tag};
      nxt_wr      = 1'b0;
      nxt_wr_addr = new_slot;
      nxt_wr_data = (count_ff == '0) ? new_slot : head_ff;
      case (state_ff)
         S_IDLE: begin
            rec_wr = req_xfer && (req.req_type == REQ_ADD) &&
                     (count_ff != CNT_BITS'(SLOTS));
            nxt_wr = rec_wr;
         end
         S_LINK: begin
            nxt_wr      = (count_ff != '0);
            nxt_wr_addr = tail_ff;
            nxt_wr_data = new_slot;
         end
         S_WALK: begin
            rec_wr      = dec.hit && dec.wr;
            rec_wr_addr = cur_ff;
            rec_wr_data = {id_q, dec.status, new_task};
         end
         default: begin
            rec_wr = 1'b0;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      type_in      = type_ff;
      id_in        = id_ff;
      task_in      = task_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_task_in  = rsp_task_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               type_in  = req.req_type;
               id_in    = req.worker_id;
               task_in  = req.task_tag;
               cur_in   = head_ff;
               steps_in = '0;
               if (req.req_type == REQ_ADD) begin
                  if (count_ff == CNT_BITS'(SLOTS)) begin
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = RC_FULL;
                     rsp_id_in    = '0;
                     rsp_task_in  = '0;
                  end else begin
                     state_in = S_LINK;
                  end
               end else if (req.req_type inside {REQ_ASSIGN, REQ_MAINT, REQ_AVAIL,
                                                 REQ_COMPLETE, REQ_EXISTS}) begin
                  if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_code_in  = (req.req_type == REQ_EXISTS) ? RC_NOT_FOUND
                                                                 : RC_EMPTY;
                     rsp_id_in    = '0;
                     rsp_task_in  = '0;
                  end else begin
                     state_in = S_WALK;
                  end
               end
            end
         end
         S_LINK: begin
            // the new slot becomes the tail
            if (count_ff == '0) begin
               head_in = new_slot;
            end
            tail_in      = new_slot;
            count_in     = count_ff + CNT_BITS'(1);
            rsp_valid_in = 1'b1;
            rsp_code_in  = RC_OK;
            rsp_id_in    = id_ff_ext[RSP_ID_BITS-1:0];
            rsp_task_in  = '0;
            state_in     = S_IDLE;
         end
         S_WALK: begin
            if (dec.hit) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = dec.code;
               rsp_id_in    = id_q_ext[RSP_ID_BITS-1:0];
               rsp_task_in  = dec.take_task ? task_q_ext[RSP_TASK_BITS-1:0] : '0;
               if (type_ff == REQ_ASSIGN) begin
                  tail_in = cur_ff;
                  head_in = nxt_q;
               end
               state_in = S_IDLE;
            end else if (last_step) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = (type_ff == REQ_ASSIGN) ? RC_NONE_AVAIL : RC_NOT_FOUND;
               rsp_id_in    = '0;
               rsp_task_in  = '0;
               state_in     = S_IDLE;
            end else begin
               // advance to the next slot in the ring
               cur_in   = nxt_q;
               steps_in = steps_ff + CNT_BITS'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      steps_ff    <= steps_in;
      type_ff     <= type_in;
      id_ff       <= id_in;
      task_ff     <= task_in;
      rsp_code_ff <= rsp_code_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_task_ff <= rsp_task_in;
   end

`ifndef SYNTHESIS
   // ring never holds more workers than slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(SLOTS))
      else $error("worker count exceeds slot count");

   // a walk never runs past the number of workers
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (steps_ff < count_ff) && (count_ff != '0))
      else $error("ring walk ran past the worker count");

   // a link step adds exactly one worker
   a_link_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |=> (count_ff == $past(count_ff) + CNT_BITS'(1)))
      else $error("add did not grow the ring by one");

   // tail always points at a filled slot
   a_tail_filled: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (CNT_BITS'(tail_ff) < count_ff))
      else $error("tail points past the filled slots");
`endif

endmodule
